// ----- rtl/sit_pkg.sv -----
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and constants for the sorted insertion table: capacity,
// derived widths, command and status codes, cell entry and control structs.
// ----------------------------------------------------------------------------
package sit_pkg;

    // table size and derived widths
    localparam int CAPACITY = 256;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FILL_W   = $clog2(CAPACITY + 1);

    // field widths
    localparam int DATE_W   = 27;
    localparam int PRICE_W  = 64;
    localparam int ID_W     = 16;
    localparam int RIDX_W   = 9;
    localparam int CNT_W    = 9;

    // configuration port
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    typedef enum logic {
        CMD_ADD  = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_OOB      = 2'd3
    } status_t;

    // register word index (byte address bit 2)
    typedef enum logic {
        REG_ASSET_ID = 1'b0,
        REG_NONE     = 1'b1
    } reg_idx_t;

    // one stored record
    typedef struct packed {
        logic                valid;
        logic [DATE_W-1:0]   date;
        logic [PRICE_W-1:0]  price;
    } entry_t;

    // insert control broadcast to every cell
    typedef struct packed {
        logic                upd;
        logic [DATE_W-1:0]   date;
        logic [PRICE_W-1:0]  price;
    } ctrl_t;

endpackage

// ----- rtl/sit_cell.sv -----
// ----------------------------------------------------------------------------
// sit_cell
// One slot of the sorted table. Compares its record with the incoming date,
// then on an insert either keeps its record, takes its left neighbor's record
// or takes the new record.
// ----------------------------------------------------------------------------
module sit_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  sit_pkg::ctrl_t  ctrl,
    input  logic            left_ins,
    input  sit_pkg::entry_t left_entry,
    output logic            ins,
    output sit_pkg::entry_t entry
);

    logic                         valid_reg;
    logic                         valid_next;
    logic [sit_pkg::DATE_W-1:0]   date_reg;
    logic [sit_pkg::DATE_W-1:0]   date_next;
    logic [sit_pkg::PRICE_W-1:0]  price_reg;
    logic [sit_pkg::PRICE_W-1:0]  price_next;

    // slot is displaced when empty or holding a strictly later date
    assign ins = !valid_reg || (date_reg > ctrl.date);

    // shift from the left or take the new record
    always_comb begin
        valid_next = valid_reg;
        date_next  = date_reg;
        price_next = price_reg;
        if (ctrl.upd && ins) begin
            if (left_ins) begin
                valid_next = left_entry.valid;
                date_next  = left_entry.date;
                price_next = left_entry.price;
            end else begin
                valid_next = 1'b1;
                date_next  = ctrl.date;
                price_next = ctrl.price;
            end
        end
    end

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // record payload
    always_ff @(posedge aclk) begin
        date_reg  <= date_next;
        price_reg <= price_next;
    end

    assign entry.valid = valid_reg;
    assign entry.date  = date_reg;
    assign entry.price = price_reg;

endmodule

// ----- rtl/sit_chain.sv -----
// ----------------------------------------------------------------------------
// sit_chain
// Row of table cells linked left to right, plus the read selector that
// returns the record at a position (null when the slot is empty).
// ----------------------------------------------------------------------------
module sit_chain (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sit_pkg::ctrl_t              ctrl,
    input  logic [sit_pkg::IDX_W-1:0]   rd_idx,
    output logic [sit_pkg::DATE_W-1:0]  rd_date,
    output logic [sit_pkg::PRICE_W-1:0] rd_price
);

    logic            ins_vec [sit_pkg::CAPACITY];
    sit_pkg::entry_t entries [sit_pkg::CAPACITY];
    sit_pkg::entry_t rd_entry;

    // cell row
    for (genvar k = 0; k < sit_pkg::CAPACITY; k++) begin : g_cell
        if (k == 0) begin : g_head
            sit_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .left_ins   (1'b0),
                .left_entry ('0),
                .ins        (ins_vec[k]),
                .entry      (entries[k])
            );
        end else begin : g_body
            sit_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .left_ins   (ins_vec[k-1]),
                .left_entry (entries[k-1]),
                .ins        (ins_vec[k]),
                .entry      (entries[k])
            );
        end
    end

    // read select, empty slot reads as null
    assign rd_entry = entries[rd_idx];
    assign rd_date  = rd_entry.valid ? rd_entry.date  : '0;
    assign rd_price = rd_entry.valid ? rd_entry.price : '0;

endmodule

// ----- rtl/sorted_insert_table.sv -----
// ----------------------------------------------------------------------------
// sorted_insert_table
// Fixed-size table of dated price records kept in date order. Add items
// insert before the first later date; read items return a slot.
// ----------------------------------------------------------------------------
//  channel   ports                                   role
//  s_        s_valid/s_ready, command..read_index    add or read item in
//  m_        m_valid/m_ready, status..fill_count     one result per item
//  apb       psel/penable/pwrite/paddr/pwdata/...    asset_id register
//
//  One item per cycle unless stalled: every cell compares and shifts in the
//  same cycle, so an insert completes in the accepting cycle and the result
//  is registered for the next. The output register frees when m_ready takes
//  it; s_ready is high whenever that register is empty or being drained.
//  Reset empties every cell, clears the fill count and asset_id.
// ----------------------------------------------------------------------------
module sorted_insert_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [sit_pkg::ID_W-1:0]      s_owner_id,
    input  logic [sit_pkg::DATE_W-1:0]    s_date_key,
    input  logic [sit_pkg::PRICE_W-1:0]   s_price_bits,
    input  logic [sit_pkg::RIDX_W-1:0]    s_read_index,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [sit_pkg::DATE_W-1:0]    m_out_date,
    output logic [sit_pkg::PRICE_W-1:0]   m_out_price,
    output logic [sit_pkg::CNT_W-1:0]     m_fill_count,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sit_pkg::PADDR_W-1:0]   paddr,
    input  logic [sit_pkg::PDATA_W-1:0]   pwdata,
    output logic [sit_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic                          m_valid_reg;
    logic                          m_valid_next;
    sit_pkg::status_t              status_reg;
    sit_pkg::status_t              status_next;
    logic [sit_pkg::DATE_W-1:0]    date_reg;
    logic [sit_pkg::DATE_W-1:0]    date_next;
    logic [sit_pkg::PRICE_W-1:0]   price_reg;
    logic [sit_pkg::PRICE_W-1:0]   price_next;
    logic [sit_pkg::CNT_W-1:0]     count_reg;
    logic [sit_pkg::CNT_W-1:0]     count_next;
    logic [sit_pkg::FILL_W-1:0]    filled_reg;
    logic [sit_pkg::FILL_W-1:0]    filled_next;
    logic [sit_pkg::ID_W-1:0]      asset_id_reg;
    logic [sit_pkg::ID_W-1:0]      asset_id_next;

    logic                          accept;
    logic                          is_add;
    logic                          full;
    logic                          match;
    logic                          oob;
    logic                          cfg_wr;
    sit_pkg::reg_idx_t             reg_sel;
    sit_pkg::ctrl_t                ctrl;
    logic [sit_pkg::IDX_W-1:0]     rd_idx;
    logic [sit_pkg::DATE_W-1:0]    rd_date;
    logic [sit_pkg::PRICE_W-1:0]   rd_price;

    // handshake
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // item decode
    assign is_add = (sit_pkg::cmd_t'(s_command) == sit_pkg::CMD_ADD);
    assign full   = (filled_reg == sit_pkg::FILL_W'(sit_pkg::CAPACITY));
    assign match  = (s_owner_id == asset_id_reg);
    assign oob    = (32'(s_read_index) >= 32'(sit_pkg::CAPACITY));
    assign rd_idx = sit_pkg::IDX_W'(s_read_index);

    // insert control to the cell row
    assign ctrl.upd   = accept && is_add && !full && match;
    assign ctrl.date  = s_date_key;
    assign ctrl.price = s_price_bits;

    sit_chain u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .rd_idx   (rd_idx),
        .rd_date  (rd_date),
        .rd_price (rd_price)
    );

    // fill count
    assign filled_next = ctrl.upd ? filled_reg + 1'b1 : filled_reg;

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        date_next    = date_reg;
        price_next   = price_reg;
        count_next   = count_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            date_next    = '0;
            price_next   = '0;
            count_next   = sit_pkg::CNT_W'(filled_next);
            if (is_add) begin
                if (full) begin
                    status_next = sit_pkg::ST_FULL;
                end else if (!match) begin
                    status_next = sit_pkg::ST_MISMATCH;
                end else begin
                    status_next = sit_pkg::ST_OK;
                end
            end else if (oob) begin
                status_next = sit_pkg::ST_OOB;
            end else begin
                status_next = sit_pkg::ST_OK;
                date_next   = rd_date;
                price_next  = rd_price;
            end
        end
    end

    // register decode and write
    assign reg_sel = sit_pkg::reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        asset_id_next = asset_id_reg;
        if (cfg_wr) begin
            case (reg_sel)
                sit_pkg::REG_ASSET_ID: asset_id_next = pwdata[sit_pkg::ID_W-1:0];
                default:               asset_id_next = asset_id_reg;
            endcase
        end
    end

    // register read
    always_comb begin
        case (reg_sel)
            sit_pkg::REG_ASSET_ID: prdata = sit_pkg::PDATA_W'(asset_id_reg);
            default:               prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            filled_reg   <= '0;
            asset_id_reg <= '0;
        end else begin
            m_valid_reg  <= m_valid_next;
            filled_reg   <= filled_next;
            asset_id_reg <= asset_id_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        date_reg   <= date_next;
        price_reg  <= price_next;
        count_reg  <= count_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_out_date   = date_reg;
    assign m_out_price  = price_reg;
    assign m_fill_count = count_reg;

endmodule

// ----- dv/sorted_insert_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_table_tb
// Sends add and read transfers into the sorted record table while the
// asset id register is rewritten between phases. A scoreboard keeps its own
// date-ordered copy of the table and checks every result field by field.
// ----------------------------------------------------------------------------
module sorted_insert_table_tb;

    localparam int                         LIMIT_CYCLES = 200000;
    localparam logic [sit_pkg::DATE_W-1:0] DATE_MAX     = 27'd99991231;
    localparam logic [sit_pkg::DATE_W-1:0] DATE_BASE    = 27'd20240101;

    // one expected result transfer
    typedef struct {
        sit_pkg::status_t             status;
        logic [sit_pkg::DATE_W-1:0]   date;
        logic [sit_pkg::PRICE_W-1:0]  price;
        logic [sit_pkg::CNT_W-1:0]    fill;
    } quote_t;

    // shadow table and queue of results still to come
    class quote_scoreboard;
        logic [sit_pkg::DATE_W-1:0]  dates  [sit_pkg::CAPACITY];
        logic [sit_pkg::PRICE_W-1:0] prices [sit_pkg::CAPACITY];
        int                          stored;
        logic [sit_pkg::ID_W-1:0]    asset;
        quote_t                      due [$];
        int                          errors;

        function new();
            foreach (dates[k]) begin
                dates[k]  = '0;
                prices[k] = '0;
            end
            stored = 0;
            asset  = '0;
            errors = 0;
        endfunction

        function void set_asset(logic [sit_pkg::ID_W-1:0] id);
            asset = id;
        endfunction

        function int outstanding();
            return due.size();
        endfunction

        // work out the result of one accepted input transfer
        function void apply_item(sit_pkg::cmd_t cmd, logic [sit_pkg::ID_W-1:0] owner,
                                 logic [sit_pkg::DATE_W-1:0] date,
                                 logic [sit_pkg::PRICE_W-1:0] price,
                                 logic [sit_pkg::RIDX_W-1:0] idx);
            quote_t q;
            int     slot;
            int     k;
            q.status = sit_pkg::ST_OK;
            q.date   = '0;
            q.price  = '0;
            if (cmd == sit_pkg::CMD_ADD) begin
                // full is checked before the owner
                if (stored >= sit_pkg::CAPACITY) begin
                    q.status = sit_pkg::ST_FULL;
                end else if (owner != asset) begin
                    q.status = sit_pkg::ST_MISMATCH;
                end else begin
                    // first slot with a strictly later date, equal dates keep order
                    slot = 0;
                    while (slot < stored && dates[slot] <= date) slot++;
                    for (k = stored; k > slot; k--) begin
                        dates[k]  = dates[k-1];
                        prices[k] = prices[k-1];
                    end
                    dates[slot]  = date;
                    prices[slot] = price;
                    stored++;
                end
            end else if (idx >= sit_pkg::CAPACITY) begin
                q.status = sit_pkg::ST_OOB;
            end else begin
                q.date  = dates[idx];
                q.price = prices[idx];
            end
            q.fill = sit_pkg::CNT_W'(stored);
            due.push_back(q);
        endfunction

        task flag(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        // compare one result transfer with the oldest expectation
        task check_result(logic [1:0] st, logic [sit_pkg::DATE_W-1:0] d,
                          logic [sit_pkg::PRICE_W-1:0] p, logic [sit_pkg::CNT_W-1:0] f);
            quote_t q;
            if (due.size() == 0) begin
                flag($sformatf("result with nothing outstanding, status %0d", st));
            end else begin
                q = due.pop_front();
                if (st !== q.status)
                    flag($sformatf("status got %0d want %0d", st, q.status));
                if (d !== q.date)
                    flag($sformatf("out_date got %0d want %0d", d, q.date));
                if (p !== q.price)
                    flag($sformatf("out_price got %h want %h", p, q.price));
                if (f !== q.fill)
                    flag($sformatf("fill_count got %0d want %0d", f, q.fill));
            end
        endtask
    endclass

    logic                          aclk         = 1'b0;
    logic                          aresetn      = 1'b0;
    logic                          s_valid      = 1'b0;
    logic                          s_ready;
    logic                          s_command    = 1'b0;
    logic [sit_pkg::ID_W-1:0]      s_owner_id   = '0;
    logic [sit_pkg::DATE_W-1:0]    s_date_key   = '0;
    logic [sit_pkg::PRICE_W-1:0]   s_price_bits = '0;
    logic [sit_pkg::RIDX_W-1:0]    s_read_index = '0;
    logic                          m_valid;
    logic                          m_ready      = 1'b0;
    logic [1:0]                    m_status;
    logic [sit_pkg::DATE_W-1:0]    m_out_date;
    logic [sit_pkg::PRICE_W-1:0]   m_out_price;
    logic [sit_pkg::CNT_W-1:0]     m_fill_count;
    logic                          psel         = 1'b0;
    logic                          penable      = 1'b0;
    logic                          pwrite       = 1'b0;
    logic [sit_pkg::PADDR_W-1:0]   paddr        = '0;
    logic [sit_pkg::PDATA_W-1:0]   pwdata       = '0;
    logic [sit_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    quote_scoreboard      board;
    bit                   calm         = 1'b0;
    int unsigned          cycles       = 0;

    sorted_insert_table dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_owner_id   (s_owner_id),
        .s_date_key   (s_date_key),
        .s_price_bits (s_price_bits),
        .s_read_index (s_read_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_out_date   (m_out_date),
        .m_out_price  (m_out_price),
        .m_fill_count (m_fill_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // monitor both channels on the sampled edge values
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                board.check_result(m_status, m_out_date, m_out_price, m_fill_count);
            if (s_valid && s_ready)
                board.apply_item(sit_pkg::cmd_t'(s_command), s_owner_id, s_date_key,
                                 s_price_bits, s_read_index);
        end
    end

    // result side backpressure in bursts, none once calm
    initial begin
        int n;
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 15);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge aclk);
        end
    end

    function automatic logic [sit_pkg::PRICE_W-1:0] rand_price();
        return {$urandom, $urandom};
    endfunction

    // clustered dates give many equal keys, the rest span 0 to DATE_MAX
    function automatic logic [sit_pkg::DATE_W-1:0] rand_date();
        if ($urandom_range(0, 1) == 0)
            return DATE_BASE + sit_pkg::DATE_W'($urandom_range(0, 7));
        return sit_pkg::DATE_W'($urandom_range(0, 99991231));
    endfunction

    // one input transfer; valid stays high until the next gap
    task automatic send_item(sit_pkg::cmd_t cmd, logic [sit_pkg::ID_W-1:0] owner,
                             logic [sit_pkg::DATE_W-1:0] date,
                             logic [sit_pkg::PRICE_W-1:0] price,
                             logic [sit_pkg::RIDX_W-1:0] idx);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_owner_id   <= owner;
        s_date_key   <= date;
        s_price_bits <= price;
        s_read_index <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_add(logic [sit_pkg::ID_W-1:0] owner,
                            logic [sit_pkg::DATE_W-1:0] date,
                            logic [sit_pkg::PRICE_W-1:0] price);
        send_item(sit_pkg::CMD_ADD, owner, date, price, sit_pkg::RIDX_W'($urandom));
    endtask

    // unused fields carry junk
    task automatic send_read(logic [sit_pkg::RIDX_W-1:0] idx);
        send_item(sit_pkg::CMD_READ, sit_pkg::ID_W'($urandom), sit_pkg::DATE_W'($urandom),
                  rand_price(), idx);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.outstanding() != 0) @(posedge aclk);
    endtask

    // apb write: setup then access
    task automatic write_reg(sit_pkg::reg_idx_t r, logic [sit_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (r == sit_pkg::REG_ASSET_ID) board.set_asset(value[sit_pkg::ID_W-1:0]);
    endtask

    task automatic random_item(logic [sit_pkg::ID_W-1:0] owner);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            send_add(owner, rand_date(), rand_price());
        else if (pick == 6)
            send_add(sit_pkg::ID_W'($urandom), rand_date(), rand_price());
        else if (pick == 7)
            send_read(sit_pkg::RIDX_W'($urandom_range(0, board.stored)));
        else if (pick == 8)
            send_read(sit_pkg::RIDX_W'($urandom_range(0, sit_pkg::CAPACITY - 1)));
        else
            send_read(sit_pkg::RIDX_W'($urandom));
    endtask

    // stimulus
    initial begin
        logic [sit_pkg::ID_W-1:0] owner;
        int                       n;
        board = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table reads, last slot, out of bound
        send_read('0);
        send_read(sit_pkg::RIDX_W'(sit_pkg::CAPACITY - 1));
        send_read(sit_pkg::RIDX_W'(sit_pkg::CAPACITY));
        send_read('1);

        // asset id still at reset value zero
        send_add(16'hFFFF, 27'd1, '1);
        send_add('0, DATE_BASE, 64'h0123_4567_89AB_CDEF);
        send_add('0, '0, '1);
        send_add('0, DATE_MAX, '0);
        send_add('0, DATE_BASE, 64'h8000_0000_0000_0001);
        send_add('0, 27'd19700101, 64'h7FFF_FFFF_FFFF_FFFE);
        for (n = 0; n < 6; n++) send_read(sit_pkg::RIDX_W'(n));

        // all-ones asset id, junk in the upper data bits
        drain();
        write_reg(sit_pkg::REG_ASSET_ID, 32'hA5A5_FFFF);
        send_add('0, DATE_BASE, rand_price());
        send_add(16'hFFFF, DATE_MAX, rand_price());
        send_read(sit_pkg::RIDX_W'(5));
        send_read(sit_pkg::RIDX_W'(6));

        // unmapped register write leaves asset id alone
        drain();
        write_reg(sit_pkg::REG_NONE, 32'h0000_1234);
        send_add(16'h1234, 27'd20000229, rand_price());
        send_add(16'hFFFF, 27'd20000229, rand_price());

        // random phases with a fresh asset id each
        drain();
        owner = sit_pkg::ID_W'($urandom);
        write_reg(sit_pkg::REG_ASSET_ID, {16'($urandom), owner});
        for (n = 0; n < 200; n++) random_item(owner);

        drain();
        owner = sit_pkg::ID_W'($urandom);
        write_reg(sit_pkg::REG_ASSET_ID, {16'($urandom), owner});
        for (n = 0; n < 200; n++) random_item(owner);

        // table fills up here, then full adds with any owner
        drain();
        owner = '0;
        write_reg(sit_pkg::REG_ASSET_ID, {16'($urandom), owner});
        for (n = 0; n < 120; n++) random_item(owner);

        // last stretch without idling on either side
        calm = 1'b1;
        for (n = 0; n < 100; n++) random_item(owner);

        drain();
        repeat (4) @(posedge aclk);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sorted_insert_table.f -----
rtl/sit_pkg.sv
rtl/sit_cell.sv
rtl/sit_chain.sv
rtl/sorted_insert_table.sv
dv/sorted_insert_table_tb.sv
